### rtl/midpoint_ellipse_rasterizer_macros.svh
// Assertion helpers for the ellipse rasterizer.
// All checks sample on the rising clock edge and are off while reset is high.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// Same-cycle implication
`define MER_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mer_pkg.sv
`default_nettype none

package mer_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SEED_MUL,
      ST_SEED,
      ST_CMP_R,
      ST_CMP,
      ST_SW_TT,
      ST_SW_AY,
      ST_SW_AYY,
      ST_SW_AB,
      ST_SW_FIN,
      ST_EMIT,
      ST_UPD_X,
      ST_UPD_Y
   } state_type;

endpackage

`default_nettype wire

### rtl/midpoint_ellipse_rasterizer.sv
// Channel | Dir | tdata (low bit up)                                   | tuser    | tlast
// req_    | in  | center_x, center_y, semi_axis_x, semi_axis_y, pad 0 | req_type | -
// rsp_    | out | x_right, x_left, y_lower, y_upper, pad 0            | -        | last_point
//
// One shared multiplier with a registered product, under a small sequencer.
// Start beat: accept, three products, seed sum. Step beat in region 1: compare,
// emit, update; the step entering region 2 adds the chained seed products; region 2:
// emit, update; the last set only emits; a step while idle is only accepted.
// Synchronous reset clears the sequencer, busy and region flags and output valid.
// One result register; the next beat is taken while it waits, a stall holds emit.
`default_nettype none
`include "midpoint_ellipse_rasterizer_macros.svh"

module midpoint_ellipse_rasterizer
   import mer_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int AXIS_BITS  = 11
) (
   input  wire                                                  clock,
   input  wire                                                  reset,
   input  wire                                                  req_tvalid,
   output logic                                                 req_tready,
   // center_x, center_y, semi_axis_x, semi_axis_y, zero pad
   input  wire  [((2*COORD_BITS+2*AXIS_BITS+7)/8)*8-1:0]        req_tdata,
   // req_type
   input  wire                                                  req_tuser,
   output logic                                                 rsp_tvalid,
   input  wire                                                  rsp_tready,
   // x_right, x_left, y_lower, y_upper, zero pad
   output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0]                rsp_tdata,
   output logic                                                 rsp_tlast
);

   localparam int CW    = COORD_BITS;
   localparam int AW    = AXIS_BITS;
   localparam int OW    = COORD_BITS + 2;
   localparam int SW    = 2 * AXIS_BITS;
   localparam int YW    = (AXIS_BITS > COORD_BITS) ? AXIS_BITS : COORD_BITS;
   localparam int TW    = (YW > AXIS_BITS + 2) ? YW : AXIS_BITS + 2;
   localparam int MA    = SW + TW;
   localparam int MB    = (SW > TW) ? SW : TW;
   localparam int PW    = MA + MB;
   localparam int DW    = SW + 2 * TW + 3;
   localparam int OUT_W = ((4 * OW + 7) / 8) * 8;
   localparam logic [YW-1:0] Y_MASK = YW'((64'd1 << COORD_BITS) - 64'd1);

   // sequencer and flags
   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      reg2_ff, reg2_in;
   logic      incx_ff, incx_in;
   logic      decy_ff, decy_in;
   logic      ysub_ff, ysub_in;

   // ellipse state
   logic [AW-1:0]        x_ff, x_in;
   logic [YW-1:0]        y_ff, y_in;
   logic signed [DW-1:0] dec_ff, dec_in;
   logic [CW-1:0]        ox_ff, ox_in;
   logic [CW-1:0]        oy_ff, oy_in;
   logic [AW-1:0]        a_ff, a_in;
   logic [SW-1:0]        a2_ff, a2_in;
   logic [SW-1:0]        b2_ff, b2_in;

   // shared multiplier
   logic [MA-1:0] op_a;
   logic [MB-1:0] op_b;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0] tmp_ff, tmp_in;
   logic [DW-1:0] prod_dw;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   // request fields
   logic [CW-1:0] cx, cy;
   logic [AW-1:0] sa, sb;
   logic          req_fire;

   // derived terms
   logic [AW:0]   x_inc;
   logic [AW+1:0] t1, t3;
   logic [YW-1:0] y_dec, ym;
   logic          dec_neg, dec_pos, last, slot_free, rsp_load;
   logic          r1_update;
   logic [OW-1:0] x_right, x_left, y_lower, y_upper;

   assign cx = req_tdata[CW-1:0];
   assign cy = req_tdata[2*CW-1:CW];
   assign sa = req_tdata[2*CW+AW-1:2*CW];
   assign sb = req_tdata[2*CW+2*AW-1:2*CW+AW];

   assign req_fire  = req_tvalid && req_tready;
   assign x_inc     = {1'b0, x_ff} + (AW+1)'(1);
   assign t1        = {1'b0, x_ff, 1'b1};
   assign t3        = {x_inc, 1'b1};
   assign y_dec     = y_ff - YW'(1);
   assign ym        = (y_ff == '0) ? YW'(1) : y_dec;
   assign dec_neg   = dec_ff[DW-1];
   assign dec_pos   = !dec_neg && (dec_ff != '0);
   assign last      = reg2_ff && (y_ff == '0);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign prod_dw   = DW'(prod_ff);
   assign r1_update = (state_ff == ST_UPD_Y) && !reg2_ff;

   // four mirrored coordinates, wrapped to the output width
   assign x_right = OW'(ox_ff) + OW'(x_ff);
   assign x_left  = OW'(ox_ff) - OW'(x_ff);
   assign y_lower = OW'(oy_ff) + OW'(y_ff);
   assign y_upper = OW'(oy_ff) - OW'(y_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  REQ_START: state_in = ST_SQ_A;
                  REQ_STEP: begin
                     if (busy_ff) begin
                        state_in = reg2_ff ? ST_EMIT : ST_CMP_R;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQ_A:     state_in = ST_SQ_B;
         ST_SQ_B:     state_in = ST_SEED_MUL;
         ST_SEED_MUL: state_in = ST_SEED;
         ST_SEED:     state_in = ST_IDLE;
         ST_CMP_R:    state_in = ST_CMP;
         ST_CMP:      state_in = (tmp_ff > prod_ff) ? ST_SW_TT : ST_EMIT;
         ST_SW_TT:    state_in = ST_SW_AY;
         ST_SW_AY:    state_in = ST_SW_AYY;
         ST_SW_AYY:   state_in = ST_SW_AB;
         ST_SW_AB:    state_in = ST_SW_FIN;
         ST_SW_FIN:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               state_in = last ? ST_IDLE : ST_UPD_X;
            end
         end
         ST_UPD_X:    state_in = ST_UPD_Y;
         ST_UPD_Y:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier operand select
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_load   = (state_ff == ST_EMIT) && slot_free;
      op_a       = '0;
      op_b       = '0;
      case (state_ff)
         ST_IDLE: begin
            op_a = MA'(b2_ff);
            op_b = MB'(x_ff);
         end
         ST_SQ_A: begin
            op_a = MA'(a_ff);
            op_b = MB'(a_ff);
         end
         ST_SQ_B: begin
            op_a = MA'(y_ff);
            op_b = MB'(y_ff);
         end
         ST_SEED_MUL: begin
            op_a = MA'(a2_ff);
            op_b = MB'(y_ff);
         end
         ST_CMP_R: begin
            op_a = MA'(a2_ff);
            op_b = MB'(y_ff);
         end
         ST_CMP: begin
            op_a = MA'(b2_ff);
            op_b = MB'(t1);
         end
         ST_SW_TT: begin
            op_a = prod_ff[MA-1:0];
            op_b = MB'(t1);
         end
         ST_SW_AY: begin
            op_a = MA'(a2_ff);
            op_b = MB'(ym);
         end
         ST_SW_AYY: begin
            op_a = prod_ff[MA-1:0];
            op_b = MB'(ym);
         end
         ST_SW_AB: begin
            op_a = MA'(a2_ff);
            op_b = MB'(b2_ff);
         end
         ST_EMIT: begin
            op_a = MA'(b2_ff);
            op_b = reg2_ff ? MB'(x_inc) : MB'(t3);
         end
         ST_UPD_X: begin
            op_a = MA'(a2_ff);
            op_b = decy_ff ? MB'(y_dec) : MB'(y_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      busy_in      = busy_ff;
      reg2_in      = reg2_ff;
      incx_in      = incx_ff;
      decy_in      = decy_ff;
      ysub_in      = ysub_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dec_in       = dec_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      a_in         = a_ff;
      a2_in        = a2_ff;
      b2_in        = b2_ff;
      tmp_in       = tmp_ff;
      prod_in      = op_a * op_b;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         // load a new ellipse; zero axes count as one
         ST_IDLE: begin
            if (req_fire && req_tuser == REQ_START) begin
               ox_in   = cx;
               oy_in   = cy;
               a_in    = (sa == '0) ? AW'(1) : sa;
               y_in    = (sb == '0) ? YW'(1) : YW'(sb);
               x_in    = '0;
               reg2_in = 1'b0;
               busy_in = 1'b1;
            end
         end
         ST_SQ_B:     a2_in = SW'(prod_ff);
         ST_SEED_MUL: b2_in = SW'(prod_ff);
         // 4*b^2 - 4*a^2*b + a^2
         ST_SEED: begin
            dec_in = $signed(DW'(b2_ff) << 2) - $signed(prod_dw << 2)
                     + $signed(DW'(a2_ff));
         end
         ST_CMP_R:  tmp_in = prod_ff;
         // region 2 seed: b^2*t^2 + 4*a^2*ym^2 - 4*a^2*b^2
         ST_SW_AY:  dec_in = $signed(prod_dw);
         ST_SW_AB:  dec_in = dec_ff + $signed(prod_dw << 2);
         ST_SW_FIN: begin
            dec_in  = dec_ff - $signed(prod_dw << 2);
            reg2_in = 1'b1;
         end
         // hand the point set to the output register, pick the update branch
         ST_EMIT: begin
            incx_in = !reg2_ff || !dec_pos;
            decy_in = reg2_ff || (!dec_neg && y_ff != '0);
            ysub_in = reg2_ff || !dec_neg;
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_W'({y_upper, y_lower, x_left, x_right});
               rsp_last_in  = last;
               if (last) begin
                  busy_in = 1'b0;
               end
            end
         end
         // b^2 term, plus 4*a^2 in region 2
         ST_UPD_X: begin
            if (reg2_ff) begin
               dec_in = dec_ff + $signed(DW'(a2_ff) << 2)
                        + (incx_ff ? $signed(prod_dw << 3) : $signed(DW'(0)));
            end else begin
               dec_in = dec_ff + $signed(prod_dw << 2);
            end
         end
         // a^2*y term and offset update
         ST_UPD_Y: begin
            if (ysub_ff) begin
               dec_in = dec_ff - $signed(prod_dw << 3);
            end
            x_in = incx_ff ? x_inc[AW-1:0] : x_ff;
            y_in = (decy_ff ? y_dec : y_ff) & Y_MASK;
         end
         default: begin
            dec_in = dec_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         reg2_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         reg2_ff      <= reg2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      incx_ff     <= incx_in;
      decy_ff     <= decy_in;
      ysub_ff     <= ysub_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dec_ff      <= dec_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      a_ff        <= a_in;
      a2_ff       <= a2_in;
      b2_ff       <= b2_in;
      prod_ff     <= prod_in;
      tmp_ff      <= tmp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // checks
   `MER_ASSERT_NOW(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT, "stray beat")
   `MER_ASSERT_NEXT(a_last_ends, rsp_load && last, !busy_ff && rsp_tlast && rsp_tvalid, "no end")
   `MER_ASSERT_NEXT(a_r1_x_step, r1_update, x_ff == $past(x_ff) + 1'b1, "x stalled in region 1")
   `MER_ASSERT_NOW(a_r2_y_falls, reg2_ff && $past(reg2_ff), y_ff <= $past(y_ff), "y rose")

endmodule

`default_nettype wire
